FILE: rtl/fuzzy_gain_interpolator_assert.svh
// Assertion macros for the fuzzy gain interpolator checker.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef FUZZY_GAIN_INTERPOLATOR_ASSERT_SVH
`define FUZZY_GAIN_INTERPOLATOR_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define FGI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another after the delay given by dly.
`define FGI_ASSERT_LATER(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

FILE: rtl/fgi_pkg.sv
// Package for the fuzzy gain interpolator: widths, codes and transfer types.
// No dependencies; imported by the top level, the checker and the testbench.
package fgi_pkg;

	localparam int FRAC_BITS  = 12;
	localparam int WORD_WIDTH = 16;
	localparam int LEVELS     = 7;
	localparam int TABLES     = 3;
	localparam int LVL_W      = 3;
	localparam int SEL_W      = 2;
	localparam int CORNERS    = 4;
	localparam int BANKS      = 4;
	localparam int BANK_AW    = 4;
	localparam int LATENCY    = 4;

	// Weight, weight product, weighted entry and four-way sum widths
	localparam int WT_W   = FRAC_BITS + 1;
	localparam int WP_W   = 2 * WT_W;
	localparam int PROD_W = WP_W + 1 + WORD_WIDTH;
	localparam int ACC_W  = PROD_W + 2;

	localparam logic [WT_W-1:0] ONE_W = WT_W'(1) << FRAC_BITS;
	localparam logic signed [WORD_WIDTH-1:0] THREE_Q = WORD_WIDTH'(3) << FRAC_BITS;
	localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 2);
	localparam logic [LVL_W-1:0] LVL_MID = LVL_W'(3);

	typedef enum logic {
		CMD_COMPUTE = 1'b0,
		CMD_WRITE   = 1'b1
	} cmd_t;

	typedef enum logic [SEL_W-1:0] {
		TBL_P = 2'd0,
		TBL_I = 2'd1,
		TBL_D = 2'd2
	} tbl_t;

	typedef struct packed {
		cmd_t                         command;
		logic signed [WORD_WIDTH-1:0] error_value;
		logic signed [WORD_WIDTH-1:0] error_change;
		logic [SEL_W-1:0]             table_select;
		logic [LVL_W-1:0]             change_level;
		logic [LVL_W-1:0]             error_level;
		logic signed [WORD_WIDTH-1:0] entry_value;
	} fgi_in_t;

	typedef struct packed {
		logic signed [WORD_WIDTH-1:0] gain_p;
		logic signed [WORD_WIDTH-1:0] gain_i;
		logic signed [WORD_WIDTH-1:0] gain_d;
		logic                         in_range;
	} fgi_out_t;

endpackage

FILE: rtl/fgi_ram.sv
// Single bank of the rule store: one write port with lane enables, one read port.
// Read data is registered. No dependencies.
module fgi_ram #(
	parameter int ADDR_W = 4,
	parameter int LANES  = 3,
	parameter int LANE_W = 16
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [ADDR_W-1:0]         wr_addr,
	input  logic [LANES-1:0]          wr_lane,
	input  logic [LANE_W-1:0]         wr_data,
	input  logic                      rd_en,
	input  logic [ADDR_W-1:0]         rd_addr,
	output logic [LANES*LANE_W-1:0]   rd_data
);

	logic [LANES-1:0][LANE_W-1:0] mem [2**ADDR_W];
	logic [LANES-1:0][LANE_W-1:0] rd_data_q;

	// Write selected lanes, read whole word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int l = 0; l < LANES; l++) begin
				if (wr_lane[l]) begin
					mem[wr_addr][l] <= wr_data;
				end
			end
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/fuzzy_gain_interpolator.sv
// Fuzzy gain interpolator: 7x7 rule tables for P, I and D blended bilinearly.
// Compute results pass stages 1 to 3 and the output register to rsp and done.
// Throughput: one transfer per cycle; busy stays low, the four rule banks give
// all twelve entries of one item in a single read cycle.
// Reset clears the pipeline valid bits; rule memory keeps whatever it holds.
// Depends on fgi_pkg and fgi_ram.
module fuzzy_gain_interpolator
	import fgi_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  fgi_in_t  req,
	output logic     done,
	output fgi_out_t rsp
);

	// Segment level of an input, 0..5
	function automatic logic [LVL_W-1:0] seg_level(input logic signed [WORD_WIDTH-1:0] x);
		logic signed [WORD_WIDTH-1:0] fl;
		fl = x >>> FRAC_BITS;
		if (x == THREE_Q) begin
			return LVL_TOP;
		end
		return LVL_W'(fl) + LVL_MID;
	endfunction

	// Right membership weight of an input
	function automatic logic [WT_W-1:0] seg_weight(input logic signed [WORD_WIDTH-1:0] x);
		if (x == THREE_Q) begin
			return ONE_W;
		end
		return {1'b0, x[FRAC_BITS-1:0]};
	endfunction

	function automatic logic in_span(input logic signed [WORD_WIDTH-1:0] x);
		return (x <= THREE_Q) && (x >= -THREE_Q);
	endfunction

	logic                 accept;
	logic                 cmp_go;
	logic                 wr_go;
	logic [LVL_W-1:0]     el;
	logic [LVL_W-1:0]     cl;
	logic [BANK_AW-1:0]   rd_addr [BANKS];
	logic [TABLES*WORD_WIDTH-1:0] bank_q [BANKS];
	logic [TABLES-1:0]    wr_lane;

	logic                 vld_s1, rng_s1, el0_s1, cl0_s1;
	logic [WT_W-1:0]      wer_s1, wcr_s1;

	logic [WP_W-1:0]              wt [CORNERS];
	logic signed [WORD_WIDTH-1:0] ent [TABLES][CORNERS];

	logic                         vld_s2, rng_s2;
	logic [WP_W-1:0]              wt_s2 [CORNERS];
	logic signed [WORD_WIDTH-1:0] ent_s2 [TABLES][CORNERS];

	logic signed [PROD_W-1:0]     prod [TABLES][CORNERS];
	logic                         vld_s3, rng_s3;
	logic signed [PROD_W-1:0]     prod_s3 [TABLES][CORNERS];

	logic signed [ACC_W-1:0]      acc [TABLES];
	logic                         done_q;
	fgi_out_t                     rsp_q;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign cmp_go  = accept && (req.command == CMD_COMPUTE);
	assign wr_go   = accept && (req.command == CMD_WRITE) && (req.table_select <= TBL_D)
		&& (req.change_level < LVL_W'(LEVELS)) && (req.error_level < LVL_W'(LEVELS));
	assign wr_lane = TABLES'(1) << req.table_select;
	assign el      = seg_level(req.error_value);
	assign cl      = seg_level(req.error_change);

	// Rule banks split by row and column parity, so the four corners never collide
	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		logic [LVL_W-1:0] row;
		logic [LVL_W-1:0] col;
		logic             bank_wr;

		assign row = (cl[0] == 1'(b >> 1)) ? cl : cl + LVL_W'(1);
		assign col = (el[0] == 1'(b)) ? el : el + LVL_W'(1);
		assign rd_addr[b] = {row[LVL_W-1:1], col[LVL_W-1:1]};
		assign bank_wr = wr_go && ({req.change_level[0], req.error_level[0]} == 2'(b));

		fgi_ram #(
			.ADDR_W(BANK_AW),
			.LANES (TABLES),
			.LANE_W(WORD_WIDTH)
		) u_ram (
			.clk    (clk),
			.wr_en  (bank_wr),
			.wr_addr({req.change_level[LVL_W-1:1], req.error_level[LVL_W-1:1]}),
			.wr_lane(wr_lane),
			.wr_data(req.entry_value),
			.rd_en  (cmp_go),
			.rd_addr(rd_addr[b]),
			.rd_data(bank_q[b])
		);
	end

	// Stage 1: hold weights and parities while the banks are read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmp_go;
		end
	end

	always_ff @(posedge clk) begin
		rng_s1 <= in_span(req.error_value) && in_span(req.error_change);
		wer_s1 <= seg_weight(req.error_value);
		wcr_s1 <= seg_weight(req.error_change);
		el0_s1 <= el[0];
		cl0_s1 <= cl[0];
	end

	// Route bank words to corners and form the corner weights
	always_comb begin
		logic [1:0]      bsel;
		logic [WT_W-1:0] wel, wcl;
		wel = ONE_W - wer_s1;
		wcl = ONE_W - wcr_s1;
		for (int k = 0; k < CORNERS; k++) begin
			bsel  = {cl0_s1 ^ k[1], el0_s1 ^ k[0]};
			wt[k] = WP_W'((k[1] ? wcr_s1 : wcl)) * WP_W'((k[0] ? wer_s1 : wel));
			for (int t = 0; t < TABLES; t++) begin
				ent[t][k] = bank_q[bsel][t*WORD_WIDTH +: WORD_WIDTH];
			end
		end
	end

	// Stage 2: hold corner weights and entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		rng_s2 <= rng_s1;
		wt_s2  <= wt;
		ent_s2 <= ent;
	end

	// Weight each entry
	always_comb begin
		for (int t = 0; t < TABLES; t++) begin
			for (int k = 0; k < CORNERS; k++) begin
				prod[t][k] = $signed({1'b0, wt_s2[k]}) * ent_s2[t][k];
			end
		end
	end

	// Stage 3: hold weighted entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		rng_s3  <= rng_s2;
		prod_s3 <= prod;
	end

	// Sum the four corners per table
	always_comb begin
		for (int t = 0; t < TABLES; t++) begin
			acc[t] = ACC_W'(prod_s3[t][0]) + ACC_W'(prod_s3[t][1])
				+ ACC_W'(prod_s3[t][2]) + ACC_W'(prod_s3[t][3]);
		end
	end

	// Output register: floor back to word format, zero when out of range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q.in_range <= rng_s3;
		rsp_q.gain_p   <= rng_s3 ? acc[TBL_P][2*FRAC_BITS +: WORD_WIDTH] : '0;
		rsp_q.gain_i   <= rng_s3 ? acc[TBL_I][2*FRAC_BITS +: WORD_WIDTH] : '0;
		rsp_q.gain_d   <= rng_s3 ? acc[TBL_D][2*FRAC_BITS +: WORD_WIDTH] : '0;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: rtl/fgi_checker.sv
// Port-level checks for the fuzzy gain interpolator, bound to the top level.
// Depends on fgi_pkg and fuzzy_gain_interpolator_assert.svh.
`include "fuzzy_gain_interpolator_assert.svh"

module fgi_checker
	import fgi_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input fgi_in_t  req,
	input logic     done,
	input fgi_out_t rsp
);

	logic cmp_xfer;
	logic wr_xfer;

	assign cmp_xfer = start && !busy && (req.command == CMD_COMPUTE);
	assign wr_xfer  = start && !busy && (req.command == CMD_WRITE);

	// Every compute transfer returns exactly one result at fixed latency
	`FGI_ASSERT_LATER(a_cmp_done, cmp_xfer, 4, done, "compute transfer gave no result")
	// A table write never produces a result
	`FGI_ASSERT_LATER(a_wr_quiet, wr_xfer, 4, !done, "table write gave a result")
	// No result without a compute transfer behind it
	`FGI_ASSERT_NOW(a_no_spurious, done, $past(cmp_xfer, LATENCY), "result without transfer")
	// Out of range results carry zero gains
	`FGI_ASSERT_NOW(a_zero_gain, done && !rsp.in_range,
		(rsp.gain_p == '0) && (rsp.gain_i == '0) && (rsp.gain_d == '0),
		"nonzero gain out of range")

endmodule

bind fuzzy_gain_interpolator fgi_checker u_fgi_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.done  (done),
	.rsp   (rsp)
);

FILE: verif/fuzzy_gain_interpolator_test.sv
// Self-checking testbench for fuzzy_gain_interpolator: rule table loads and gain blends.
// A queue-fed driver and a clocked monitor check every gain against an in-bench predictor.
// Depends on fgi_pkg and the fuzzy_gain_interpolator RTL.
`timescale 1ns / 100ps

module fuzzy_gain_interpolator_test;
	import fgi_pkg::*;

	localparam int     HALF_PERIOD    = 4;
	localparam int     RESET_CYCLES   = 6;
	localparam int     WATCHDOG_LIMIT = 2000;
	localparam int     RANDOM_ITEMS   = 732;
	localparam longint UNIT           = longint'(1) << FRAC_BITS;

	// Codes that a write may carry but that leave the rule store alone
	localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;
	localparam logic [LVL_W-1:0] LVL_NONE = 3'd7;

	// Sender idle rates per phase, in percent
	localparam int IDLE_NONE  = 0;
	localparam int IDLE_LIGHT = 8;
	localparam int IDLE_HEAVY = 85;

	typedef struct {
		fgi_in_t item;
		int      idle_pct;
		bit      drain_first;
	} pending_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	fgi_in_t  req = '0;
	logic     done;
	fgi_out_t rsp;

	pending_t stim_q [$];
	fgi_out_t expected_gains [$];
	logic signed [WORD_WIDTH-1:0] rule_words [TABLES][LEVELS][LEVELS];
	int mismatch_count = 0;
	int idle_cycles = 0;

	fuzzy_gain_interpolator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #HALF_PERIOD clk = ~clk;

	// Segment index 0..5 and right-hand weight of one input in -3..3
	function automatic void place_level(input logic signed [WORD_WIDTH-1:0] x,
			output int lvl, output longint w_right);
		lvl = int'(x >>> FRAC_BITS) + 3;
		if (lvl > LEVELS - 2)
			lvl = LEVELS - 2;
		w_right = longint'(x) - longint'(lvl - 3) * UNIT;
	endfunction

	// Blend the four rule words around (error, change) for each table
	function automatic fgi_out_t blend_gains(input fgi_in_t it);
		fgi_out_t g;
		int el, cl, t, k;
		longint we_r, wc_r, we_l, wc_l, acc;
		longint wts [CORNERS];
		int rows [CORNERS];
		int cols [CORNERS];
		logic [WORD_WIDTH-1:0] gains [TABLES];
		g = '0;
		if (it.error_value > THREE_Q || it.error_value < -THREE_Q ||
				it.error_change > THREE_Q || it.error_change < -THREE_Q)
			return g;
		place_level(it.error_value, el, we_r);
		place_level(it.error_change, cl, wc_r);
		we_l = UNIT - we_r;
		wc_l = UNIT - wc_r;
		wts  = '{we_l * wc_l, we_l * wc_r, we_r * wc_l, we_r * wc_r};
		rows = '{cl, cl + 1, cl, cl + 1};
		cols = '{el, el, el + 1, el + 1};
		for (t = 0; t < TABLES; t++) begin
			acc = 0;
			for (k = 0; k < CORNERS; k++)
				acc += wts[k] * longint'(rule_words[t][rows[k]][cols[k]]);
			gains[t] = WORD_WIDTH'(acc >>> (2 * FRAC_BITS));
		end
		g.gain_p   = gains[TBL_P];
		g.gain_i   = gains[TBL_I];
		g.gain_d   = gains[TBL_D];
		g.in_range = 1'b1;
		return g;
	endfunction

	// Random Q3.12 value, mostly inside -3..3 with levels and edges favored
	function automatic logic signed [WORD_WIDTH-1:0] rand_q();
		int v;
		case ($urandom_range(0, 9))
			6, 7: v = (int'($urandom_range(0, LEVELS - 1)) - 3) * int'(UNIT);
			8: v = ($urandom_range(0, 1) ? 1 : -1) * (int'(THREE_Q) + int'($urandom_range(0, 2)) - 1);
			9: v = int'($urandom());
			default: v = int'($urandom_range(0, 2 * THREE_Q)) - int'(THREE_Q);
		endcase
		return v[WORD_WIDTH-1:0];
	endfunction

	function automatic fgi_in_t compute_item(input logic signed [WORD_WIDTH-1:0] e,
			input logic signed [WORD_WIDTH-1:0] ec);
		fgi_in_t it;
		it              = fgi_in_t'({$urandom(), $urandom(), $urandom()});
		it.command      = CMD_COMPUTE;
		it.error_value  = e;
		it.error_change = ec;
		return it;
	endfunction

	function automatic fgi_in_t write_item(input logic [SEL_W-1:0] sel,
			input logic [LVL_W-1:0] row, input logic [LVL_W-1:0] col,
			input logic signed [WORD_WIDTH-1:0] val);
		fgi_in_t it;
		it              = fgi_in_t'({$urandom(), $urandom(), $urandom()});
		it.command      = CMD_WRITE;
		it.table_select = sel;
		it.change_level = row;
		it.error_level  = col;
		it.entry_value  = val;
		return it;
	endfunction

	task automatic queue_item(input fgi_in_t it, input int idle_pct, input bit drain);
		pending_t p;
		p.item        = it;
		p.idle_pct    = idle_pct;
		p.drain_first = drain;
		stim_q.push_back(p);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("%0t ns: %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	// Driver: predict each accepted transfer, then load the next pending item
	always @(posedge clk) begin
		pending_t nxt;
		bit go;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				if (req.command == CMD_WRITE) begin
					if (req.table_select < TABLES && req.change_level < LEVELS &&
							req.error_level < LEVELS)
						rule_words[req.table_select][req.change_level][req.error_level] =
							req.entry_value;
				end else begin
					expected_gains.push_back(blend_gains(req));
				end
			end
			if (!start || !busy) begin
				go = 1'b0;
				if (stim_q.size() != 0) begin
					nxt = stim_q[0];
					go  = $urandom_range(0, 99) >= nxt.idle_pct;
					// hold the item until every pending result is out
					if (nxt.drain_first && (expected_gains.size() != 0 || done))
						go = 1'b0;
				end
				if (go) begin
					void'(stim_q.pop_front());
					start <= 1'b1;
					req   <= nxt.item;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		fgi_out_t want;
		if (arst_n && done) begin
			if (expected_gains.size() == 0) begin
				report_mismatch("result with nothing pending, gain_p", rsp.gain_p, 0);
			end else begin
				want = expected_gains.pop_front();
				if (rsp.gain_p !== want.gain_p)
					report_mismatch("gain_p", rsp.gain_p, want.gain_p);
				if (rsp.gain_i !== want.gain_i)
					report_mismatch("gain_i", rsp.gain_i, want.gain_i);
				if (rsp.gain_d !== want.gain_d)
					report_mismatch("gain_d", rsp.gain_d, want.gain_d);
				if (rsp.in_range !== want.in_range)
					report_mismatch("in_range", rsp.in_range, want.in_range);
			end
		end
	end

	// Watchdog: end the run once nothing has transferred for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int t, r, c, n, phase_idle;
		logic signed [WORD_WIDTH-1:0] val;

		// Load every rule word before any read, with P at its top corner at maximum and I at its bottom corner at minimum
		for (t = 0; t < TABLES; t++)
			for (r = 0; r < LEVELS; r++)
				for (c = 0; c < LEVELS; c++) begin
					case ($urandom_range(0, 7))
						0: val = 16'sh7fff;
						1: val = 16'sh8000;
						default: val = WORD_WIDTH'($urandom());
					endcase
					if (t == TBL_P && r == LEVELS - 1 && c == LEVELS - 1)
						val = 16'sh7fff;
					if (t == TBL_I && r == 0 && c == 0)
						val = 16'sh8000;
					queue_item(write_item(SEL_W'(t), LVL_W'(r), LVL_W'(c), val), IDLE_NONE, 1'b0);
				end

		// Directed: level edges, range limits, back-to-back writes and ignored writes
		queue_item(compute_item(16'sd0, 16'sd0), IDLE_LIGHT, 1'b1);
		queue_item(compute_item(THREE_Q, THREE_Q), IDLE_LIGHT, 1'b0);
		queue_item(compute_item(-THREE_Q, -THREE_Q), IDLE_LIGHT, 1'b0);
		queue_item(compute_item(THREE_Q, -THREE_Q), IDLE_LIGHT, 1'b0);
		queue_item(compute_item(THREE_Q + 16'sd1, 16'sd0), IDLE_LIGHT, 1'b0);
		queue_item(compute_item(16'sd0, -THREE_Q - 16'sd1), IDLE_LIGHT, 1'b0);
		queue_item(compute_item(16'sh7fff, 16'sh8000), IDLE_LIGHT, 1'b0);
		queue_item(compute_item(16'sh8000, 16'sh7fff), IDLE_LIGHT, 1'b0);
		queue_item(compute_item(16'sd1, -16'sd1), IDLE_LIGHT, 1'b0);
		queue_item(compute_item(16'sd4095, 16'sd4096), IDLE_LIGHT, 1'b0);
		queue_item(compute_item(-16'sd4097, -16'sd4096), IDLE_LIGHT, 1'b0);
		queue_item(write_item(TBL_P, LVL_MID, LVL_MID, 16'sh7fff), IDLE_NONE, 1'b0);
		queue_item(compute_item(16'sd0, 16'sd0), IDLE_NONE, 1'b0);
		queue_item(write_item(TBL_I, LVL_MID, LVL_MID, 16'sh8000), IDLE_NONE, 1'b0);
		queue_item(compute_item(16'sd2048, -16'sd2048), IDLE_NONE, 1'b0);
		queue_item(write_item(SEL_NONE, LVL_MID, LVL_MID, 16'sh1234), IDLE_NONE, 1'b0);
		queue_item(compute_item(16'sd0, 16'sd0), IDLE_NONE, 1'b0);
		queue_item(write_item(TBL_D, LVL_NONE, LVL_MID, 16'sh4321), IDLE_NONE, 1'b0);
		queue_item(write_item(TBL_D, LVL_MID, LVL_NONE, 16'sh5a5a), IDLE_NONE, 1'b0);
		queue_item(compute_item(16'sd0, 16'sd0), IDLE_NONE, 1'b0);
		queue_item(compute_item(THREE_Q - 16'sd1, 16'sd1 - THREE_Q), IDLE_NONE, 1'b0);

		// Random: three phases of sender idling, the second and third each opened by a drain
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n < RANDOM_ITEMS / 3)
				phase_idle = IDLE_LIGHT;
			else if (n < 2 * RANDOM_ITEMS / 3)
				phase_idle = IDLE_HEAVY;
			else
				phase_idle = IDLE_NONE;
			if ($urandom_range(0, 3) == 0)
				queue_item(write_item(
					($urandom_range(0, 9) == 0) ? SEL_NONE : SEL_W'($urandom_range(0, 2)),
					($urandom_range(0, 9) == 0) ? LVL_NONE : LVL_W'($urandom_range(0, 6)),
					($urandom_range(0, 9) == 0) ? LVL_NONE : LVL_W'($urandom_range(0, 6)),
					WORD_WIDTH'($urandom())),
					phase_idle, n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3);
			else
				queue_item(compute_item(rand_q(), rand_q()),
					phase_idle, n == RANDOM_ITEMS / 3 || n == 2 * RANDOM_ITEMS / 3);
		end

		// Release reset after the reset hold
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for all transfers and results, then let the pipeline settle
		@(posedge clk);
		while (stim_q.size() != 0 || start || expected_gains.size() != 0 || done)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);

		if (mismatch_count == 0 && expected_gains.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/fgi_pkg.sv
rtl/fgi_ram.sv
rtl/fuzzy_gain_interpolator.sv
rtl/fgi_checker.sv
verif/fuzzy_gain_interpolator_test.sv
